FILE: rtl/autofire_button_overlay_macros.svh
// assertion macros used by the autofire overlay rtl
`ifndef AUTOFIRE_BUTTON_OVERLAY_MACROS_SVH
`define AUTOFIRE_BUTTON_OVERLAY_MACROS_SVH

// same-cycle implication, checked out of reset
`define AFBO_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define AFBO_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/afbo_pkg.sv
// package with types, constants and the period table of the autofire overlay
package afbo_pkg;

	localparam int FUNC_W   = 3;
	localparam int BUTTON_W = 4;
	localparam int RATE_W   = 6;
	localparam int FRAME_W  = 64;
	localparam int MASK_W   = 16;
	localparam int STEP_W   = $clog2(FRAME_W);
	localparam int MASK_IDX_W = $clog2(MASK_W);

	localparam logic [RATE_W-1:0] RATE_MAX = RATE_W'(60);

	typedef enum logic [FUNC_W-1:0] {
		FUNC_ARM        = 3'd0,
		FUNC_READ       = 3'd1,
		FUNC_CLR_PLAYER = 3'd2,
		FUNC_CLR_ALL    = 3'd3,
		FUNC_QUERY      = 3'd4
	} func_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_LOAD,
		ST_DIV,
		ST_DONE
	} state_t;

	// table commands from the sequencer
	typedef struct packed {
		logic wr;
		logic rd;
		logic clr_row;
		logic clr_all;
	} tbl_cmd_t;

	// remainder unit control and status
	typedef struct packed {
		logic load;
		logic start;
	} mod_ctl_t;

	typedef struct packed {
		logic done;
		logic rem_zero;
	} mod_sts_t;

	// press period in frames, 60 / rate rounded down, never below one
	function automatic logic [RATE_W-1:0] period_of(input logic [RATE_W-1:0] r);
		logic [RATE_W-1:0] p;
		case (r) inside
			[6'd31:6'd63]: p = 6'd1;
			[6'd21:6'd30]: p = 6'd2;
			[6'd16:6'd20]: p = 6'd3;
			[6'd13:6'd15]: p = 6'd4;
			[6'd11:6'd12]: p = 6'd5;
			[6'd9:6'd10]:  p = 6'd6;
			6'd8:          p = 6'd7;
			6'd7:          p = 6'd8;
			6'd6:          p = 6'd10;
			6'd5:          p = 6'd12;
			6'd4:          p = 6'd15;
			6'd3:          p = 6'd20;
			6'd2:          p = 6'd30;
			6'd1:          p = 6'd60;
			default:       p = 6'd1;
		endcase
		return p;
	endfunction

endpackage

FILE: rtl/afbo_if.sv
// request and response channel interfaces of the autofire overlay
interface afbo_req_if;
	import afbo_pkg::*;

	logic                valid;
	logic                ready;
	logic [FUNC_W-1:0]   func;
	logic                player;
	logic [BUTTON_W-1:0] button;
	logic [RATE_W-1:0]   rate;
	logic [FRAME_W-1:0]  frame;

	modport source (output valid, func, player, button, rate, frame, input ready);
	modport sink (input valid, func, player, button, rate, frame, output ready);
endinterface

interface afbo_rsp_if;
	import afbo_pkg::*;

	logic              valid;
	logic              ready;
	logic [MASK_W-1:0] pressed_mask;
	logic [RATE_W-1:0] rate_value;
	logic              player_armed;
	logic              any_armed;

	modport source (output valid, pressed_mask, rate_value, player_armed, any_armed,
		input ready);
	modport sink (input valid, pressed_mask, rate_value, player_armed, any_armed,
		output ready);
endinterface

FILE: rtl/afbo_mod.sv
// bit-serial remainder unit: frame modulo period, one frame bit per cycle
module afbo_mod (
	input  logic                             clk,
	input  logic                             arst_n,
	input  afbo_pkg::mod_ctl_t               ctl,
	input  logic [afbo_pkg::FRAME_W-1:0]     frame,
	input  logic [afbo_pkg::RATE_W-1:0]      divisor,
	output afbo_pkg::mod_sts_t               sts
);
	import afbo_pkg::*;

	logic [FRAME_W-1:0] frame_q;
	logic [RATE_W-1:0]  div_q;
	logic [RATE_W-1:0]  rem_q;
	logic [STEP_W-1:0]  cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [RATE_W:0]    trial;
	logic [RATE_W-1:0]  rem_d;

	// one restoring step: bring in the next frame bit, subtract if it fits
	always_comb begin
		trial = {rem_q, frame_q[FRAME_W-1]};
		if (trial >= {1'b0, div_q}) begin
			rem_d = RATE_W'(trial - {1'b0, div_q});
		end else begin
			rem_d = trial[RATE_W-1:0];
		end
	end

	// frame rotates so that it is whole again after each pass
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			frame_q <= frame;
		end else if (busy_q) begin
			frame_q <= {frame_q[FRAME_W-2:0], frame_q[FRAME_W-1]};
		end
		if (ctl.start) begin
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= rem_d;
		end
	end

	// step counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == STEP_W'(FRAME_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign sts.done     = done_q;
	assign sts.rem_zero = (rem_q == '0);

endmodule

FILE: rtl/afbo_table.sv
// rate table: memory of rates plus one armed flag per entry
module afbo_table #(
	parameter int BUTTONS = 16,
	parameter int PLAYERS = 2
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  afbo_pkg::tbl_cmd_t                cmd,
	input  logic                              player,
	input  logic [afbo_pkg::BUTTON_W-1:0]     button,
	input  logic [afbo_pkg::RATE_W-1:0]       wr_rate,
	output logic [afbo_pkg::RATE_W-1:0]       rd_rate,
	output logic [PLAYERS-1:0]                row_armed
);
	import afbo_pkg::*;

	localparam int ENTRIES = PLAYERS * BUTTONS;
	localparam int ENT_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int ROW_W   = (PLAYERS > 1) ? $clog2(PLAYERS) : 1;
	localparam int COL_W   = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;

	logic [RATE_W-1:0]  mem_q [ENTRIES];
	logic [BUTTONS-1:0] armed_q [PLAYERS];
	logic [RATE_W-1:0]  rd_data_q;
	logic               rd_armed_q;
	logic [ENT_W-1:0]   addr;
	logic [ROW_W-1:0]   row;
	logic [COL_W-1:0]   col;

	assign addr = ENT_W'(32'(player) * BUTTONS + 32'(button));
	assign row  = ROW_W'(player);
	assign col  = COL_W'(button);

	// rate storage, registered read
	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem_q[addr] <= wr_rate;
		end
		if (cmd.rd) begin
			rd_data_q <= mem_q[addr];
		end
	end

	// armed flags, set or cleared by writes, cleared at reset and by the clear operations
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < PLAYERS; p++) begin
				armed_q[p] <= '0;
			end
			rd_armed_q <= 1'b0;
		end else begin
			if (cmd.clr_all) begin
				for (int p = 0; p < PLAYERS; p++) begin
					armed_q[p] <= '0;
				end
			end else if (cmd.clr_row) begin
				armed_q[row] <= '0;
			end else if (cmd.wr) begin
				armed_q[row][col] <= (wr_rate != '0);
			end
			if (cmd.rd) begin
				rd_armed_q <= armed_q[row][col];
			end
		end
	end

	// an entry that is not armed reads as zero
	assign rd_rate = rd_armed_q ? rd_data_q : '0;

	always_comb begin
		for (int p = 0; p < PLAYERS; p++) begin
			row_armed[p] = |armed_q[p];
		end
	end

endmodule

FILE: rtl/autofire_button_overlay.sv
// arm, read and clear go from transfer through the done state to the result register
// frame query walks the buttons one by one
// each button costs a table read, a load step and 64 serial remainder steps
// one item at a time; the next transfer is taken once the result is registered
// reset (arst_n low) clears every rate to off and empties the result register
module autofire_button_overlay #(
	parameter int BUTTONS = 16,
	parameter int PLAYERS = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	afbo_req_if.sink   req,
	afbo_rsp_if.source rsp
);
	import afbo_pkg::*;

	`include "autofire_button_overlay_macros.svh"

	localparam int ROW_W = (PLAYERS > 1) ? $clog2(PLAYERS) : 1;
	localparam int CNT_W = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;

	state_t              state_q, state_d;
	func_t               req_func, func_q;
	logic                req_fire;
	logic                req_pl_ok, req_bt_ok;
	logic                player_q, pl_ok_q, bt_ok_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [MASK_W-1:0]   mask_q;
	logic                last_btn;
	logic                fire_bit;
	logic                out_load;
	logic [RATE_W-1:0]   arm_rate;

	tbl_cmd_t            tbl_cmd;
	logic                tbl_player;
	logic [BUTTON_W-1:0] tbl_button;
	logic [RATE_W-1:0]   tbl_rate;
	logic [PLAYERS-1:0]  row_armed;
	mod_ctl_t            mod_ctl;
	mod_sts_t            mod_sts;

	logic                rsp_valid_q;
	logic [MASK_W-1:0]   rsp_mask_q;
	logic [RATE_W-1:0]   rsp_rate_q;
	logic                rsp_parmed_q;
	logic                rsp_any_q;

	// request decode
	assign req_fire  = req.valid && req.ready;
	assign req_func  = func_t'(req.func);
	assign req_pl_ok = (32'(req.player) < PLAYERS);
	assign req_bt_ok = (32'(req.button) < BUTTONS);
	assign arm_rate  = (req.rate > RATE_MAX) ? RATE_MAX : req.rate;
	assign last_btn  = (cnt_q == CNT_W'(BUTTONS - 1));
	assign fire_bit  = (tbl_rate != '0) && ((tbl_rate >= RATE_MAX) || mod_sts.rem_zero);

	afbo_table #(
		.BUTTONS (BUTTONS),
		.PLAYERS (PLAYERS)
	) u_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (tbl_cmd),
		.player    (tbl_player),
		.button    (tbl_button),
		.wr_rate   (arm_rate),
		.rd_rate   (tbl_rate),
		.row_armed (row_armed)
	);

	afbo_mod u_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (mod_ctl),
		.frame   (req.frame),
		.divisor (period_of(tbl_rate)),
		.sts     (mod_sts)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_fire) begin
					if (req_func == FUNC_QUERY && req_pl_ok) begin
						state_d = ST_FETCH;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_FETCH: state_d = ST_LOAD;
			ST_LOAD:  state_d = ST_DIV;
			ST_DIV: begin
				if (mod_sts.done) begin
					state_d = last_btn ? ST_DONE : ST_FETCH;
				end
			end
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		req.ready  = 1'b0;
		tbl_cmd    = '0;
		tbl_player = player_q;
		tbl_button = BUTTON_W'(cnt_q);
		mod_ctl    = '0;
		out_load   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req.ready  = 1'b1;
				tbl_player = req.player;
				tbl_button = req.button;
				if (req.valid) begin
					unique case (req_func)
						FUNC_ARM:        tbl_cmd.wr      = req_pl_ok && req_bt_ok;
						FUNC_READ:       tbl_cmd.rd      = req_pl_ok && req_bt_ok;
						FUNC_CLR_PLAYER: tbl_cmd.clr_row = req_pl_ok;
						FUNC_CLR_ALL:    tbl_cmd.clr_all = 1'b1;
						FUNC_QUERY:      mod_ctl.load    = 1'b1;
						default:         tbl_cmd         = '0;
					endcase
				end
			end
			ST_FETCH: tbl_cmd.rd    = 1'b1;
			ST_LOAD:  mod_ctl.start = 1'b1;
			ST_DIV:   out_load      = 1'b0;
			ST_DONE:  out_load      = !rsp_valid_q || rsp.ready;
			default:  out_load      = 1'b0;
		endcase
	end

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			func_q   <= FUNC_ARM;
			player_q <= 1'b0;
			pl_ok_q  <= 1'b0;
			bt_ok_q  <= 1'b0;
			cnt_q    <= '0;
			mask_q   <= '0;
		end else begin
			state_q <= state_d;
			if (req_fire) begin
				func_q   <= req_func;
				player_q <= req.player;
				pl_ok_q  <= req_pl_ok;
				bt_ok_q  <= req_bt_ok;
				cnt_q    <= '0;
				mask_q   <= '0;
			end else if (state_q == ST_DIV && mod_sts.done) begin
				mask_q[MASK_IDX_W'(cnt_q)] <= fire_bit;
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			rsp_mask_q   <= (func_q == FUNC_QUERY) ? mask_q : '0;
			rsp_rate_q   <= (func_q == FUNC_READ && pl_ok_q && bt_ok_q) ? tbl_rate : '0;
			rsp_parmed_q <= pl_ok_q && row_armed[ROW_W'(player_q)];
			rsp_any_q    <= |row_armed;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.pressed_mask = rsp_mask_q;
	assign rsp.rate_value   = rsp_rate_q;
	assign rsp.player_armed = rsp_parmed_q;
	assign rsp.any_armed    = rsp_any_q;

	// checks
	`AFBO_ASSERT_NOW(a_done_in_div, mod_sts.done, state_q == ST_DIV,
		"remainder done outside the divide state")
	`AFBO_ASSERT_NEXT(a_transfer_leaves_idle, req_fire, state_q != ST_IDLE,
		"sequencer stayed idle after a request transfer")
	`AFBO_ASSERT_NEXT(a_mask_zero_non_query, out_load && func_q != FUNC_QUERY,
		rsp.pressed_mask == '0, "pressed mask set for a non-query result")
	`AFBO_ASSERT_NOW(a_mask_in_range, rsp.valid, (rsp.pressed_mask >> BUTTONS) == '0,
		"pressed mask has a bit beyond the button count")

endmodule

FILE: test/tb_autofire_button_overlay.sv
// self-checking testbench for the autofire overlay: directed and random requests under idling
module tb_autofire_button_overlay;
	import afbo_pkg::*;

	localparam int BUTTONS     = 16;
	localparam int PLAYERS     = 2;
	localparam int N_RANDOM    = 135;
	localparam int HOLD_AT     = 30;
	localparam int HOLD_LEN    = 300;
	localparam int STUCK_LIMIT = 8000;
	localparam int DRAIN_WAIT  = 20;

	// func codes the block has no operation for
	localparam logic [FUNC_W-1:0] FUNC_UNUSED_FIRST = 3'd5;
	localparam logic [FUNC_W-1:0] FUNC_UNUSED_LAST  = 3'd7;

	typedef struct packed {
		logic [FUNC_W-1:0]   func;
		logic                player;
		logic [BUTTON_W-1:0] button;
		logic [RATE_W-1:0]   rate;
		logic [FRAME_W-1:0]  frame;
	} cmd_t;

	typedef struct packed {
		logic [MASK_W-1:0] pressed_mask;
		logic [RATE_W-1:0] rate_value;
		logic              player_armed;
		logic              any_armed;
	} turbo_rsp_t;

	logic clk = 1'b0;
	logic arst_n;

	afbo_req_if req_ch();
	afbo_rsp_if rsp_ch();

	autofire_button_overlay #(
		.BUTTONS(BUTTONS),
		.PLAYERS(PLAYERS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	// predictor state: rate per player and button
	logic [RATE_W-1:0] turbo_rates [PLAYERS][BUTTONS];

	cmd_t       cmd_backlog [$];
	turbo_rsp_t turbo_expected [$];

	cmd_t       drv_cmd;
	cmd_t       seen_cmd;
	turbo_rsp_t got_rsp;
	turbo_rsp_t want_rsp;

	int src_idle_pct;
	int sink_stall_pct;
	int hold_left;
	bit hold_used;
	int sink_xfers;
	int stuck_cycles;
	int err_count;
	int n_requests;
	int n_queries;
	int n_results;
	int n_fired;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// true when a button at this rate is pressed on this frame
	function automatic logic fires(input logic [RATE_W-1:0] r, input logic [FRAME_W-1:0] f);
		logic [FRAME_W-1:0] period;
		if (r == '0)
			return 1'b0;
		if (r >= RATE_MAX)
			return 1'b1;
		period = FRAME_W'(RATE_MAX) / FRAME_W'(r);
		if (period == '0)
			period = 1;
		return (f % period) == '0;
	endfunction

	function automatic logic row_armed(input int p);
		logic hit;
		hit = 1'b0;
		for (int b = 0; b < BUTTONS; b++)
			hit |= (turbo_rates[p][b] != '0);
		return hit;
	endfunction

	// applies one request to the rate copy and returns the expected response
	function automatic turbo_rsp_t turbo_step(input cmd_t c);
		turbo_rsp_t res;
		res = '0;
		case (c.func)
			FUNC_ARM: begin
				turbo_rates[c.player][c.button] = (c.rate > RATE_MAX) ? RATE_MAX : c.rate;
			end
			FUNC_READ: begin
				res.rate_value = turbo_rates[c.player][c.button];
			end
			FUNC_CLR_PLAYER: begin
				for (int b = 0; b < BUTTONS; b++)
					turbo_rates[c.player][b] = '0;
			end
			FUNC_CLR_ALL: begin
				for (int p = 0; p < PLAYERS; p++)
					for (int b = 0; b < BUTTONS; b++)
						turbo_rates[p][b] = '0;
			end
			FUNC_QUERY: begin
				for (int b = 0; b < BUTTONS; b++)
					res.pressed_mask[b] = fires(turbo_rates[c.player][b], c.frame);
			end
			default: begin
			end
		endcase
		res.player_armed = row_armed(c.player);
		res.any_armed = 1'b0;
		for (int p = 0; p < PLAYERS; p++)
			res.any_armed |= row_armed(p);
		return res;
	endfunction

	task automatic queue_cmd(input logic [FUNC_W-1:0] f, input logic p,
			input logic [BUTTON_W-1:0] b, input logic [RATE_W-1:0] r,
			input logic [FRAME_W-1:0] fr);
		cmd_t c;
		c.func = f;
		c.player = p;
		c.button = b;
		c.rate = r;
		c.frame = fr;
		cmd_backlog = {cmd_backlog, c};
	endtask

	// mostly arms and queries so the table stays populated
	function automatic cmd_t random_cmd();
		cmd_t c;
		int pick;
		pick = $urandom_range(99);
		c.player = 1'($urandom);
		c.button = BUTTON_W'($urandom);
		c.rate = ($urandom_range(99) < 8) ? '0 : RATE_W'($urandom_range(63, 1));
		case ($urandom_range(3))
			0: c.frame = FRAME_W'($urandom_range(119));
			1: c.frame = FRAME_W'(60) * FRAME_W'($urandom_range(1000));
			2: c.frame = {$urandom, $urandom};
			default: c.frame = '1 - FRAME_W'($urandom_range(119));
		endcase
		if (pick < 38)
			c.func = FUNC_ARM;
		else if (pick < 56)
			c.func = FUNC_READ;
		else if (pick < 84)
			c.func = FUNC_QUERY;
		else if (pick < 88)
			c.func = FUNC_CLR_PLAYER;
		else if (pick < 90)
			c.func = FUNC_CLR_ALL;
		else
			c.func = FUNC_W'($urandom_range(FUNC_UNUSED_LAST, FUNC_UNUSED_FIRST));
		return c;
	endfunction

	task automatic check_field(input string name, input logic [MASK_W-1:0] want,
			input logic [MASK_W-1:0] got);
		if (got !== want) begin
			$display("%0t mismatch %s: expected %0h, actual %0h", $time, name, want, got);
			err_count++;
		end
	endtask

	// request driver, fed from the backlog
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid  <= 1'b0;
			req_ch.func   <= FUNC_ARM;
			req_ch.player <= 1'b0;
			req_ch.button <= '0;
			req_ch.rate   <= '0;
			req_ch.frame  <= '0;
		end else if (!req_ch.valid || req_ch.ready) begin
			if (cmd_backlog.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
				drv_cmd = cmd_backlog.pop_front();
				req_ch.valid  <= 1'b1;
				req_ch.func   <= drv_cmd.func;
				req_ch.player <= drv_cmd.player;
				req_ch.button <= drv_cmd.button;
				req_ch.rate   <= drv_cmd.rate;
				req_ch.frame  <= drv_cmd.frame;
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// response ready, with one long hold-off to back the block up
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			hold_left <= 0;
			hold_used <= 1'b0;
			sink_xfers <= 0;
		end else begin
			sink_xfers <= sink_xfers + int'(rsp_ch.valid && rsp_ch.ready);
			if (hold_left != 0) begin
				rsp_ch.ready <= 1'b0;
				hold_left <= hold_left - 1;
			end else if (!hold_used && sink_xfers == HOLD_AT) begin
				rsp_ch.ready <= 1'b0;
				hold_left <= HOLD_LEN;
				hold_used <= 1'b1;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
			end
		end
	end

	// monitor: check each response transfer, predict each request transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				got_rsp.pressed_mask = rsp_ch.pressed_mask;
				got_rsp.rate_value = rsp_ch.rate_value;
				got_rsp.player_armed = rsp_ch.player_armed;
				got_rsp.any_armed = rsp_ch.any_armed;
				n_results++;
				if (turbo_expected.size() == 0) begin
					$display("%0t unexpected response: expected none, actual %0h", $time,
						got_rsp);
					err_count++;
				end else begin
					want_rsp = turbo_expected.pop_front();
					check_field("pressed_mask", want_rsp.pressed_mask, got_rsp.pressed_mask);
					check_field("rate_value", MASK_W'(want_rsp.rate_value),
						MASK_W'(got_rsp.rate_value));
					check_field("player_armed", MASK_W'(want_rsp.player_armed),
						MASK_W'(got_rsp.player_armed));
					check_field("any_armed", MASK_W'(want_rsp.any_armed),
						MASK_W'(got_rsp.any_armed));
					if (want_rsp.pressed_mask != '0)
						n_fired++;
				end
			end
			if (req_ch.valid && req_ch.ready) begin
				seen_cmd.func = req_ch.func;
				seen_cmd.player = req_ch.player;
				seen_cmd.button = req_ch.button;
				seen_cmd.rate = req_ch.rate;
				seen_cmd.frame = req_ch.frame;
				n_requests++;
				if (seen_cmd.func == FUNC_QUERY)
					n_queries++;
				turbo_expected = {turbo_expected, turbo_step(seen_cmd)};
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles == STUCK_LIMIT) begin
			$display("%0t no transfer for %0d cycles", $time, STUCK_LIMIT);
			$display("CHECK FAILED");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	initial begin
		arst_n = 1'b0;
		src_idle_pct = 0;
		sink_stall_pct = 0;
		err_count = 0;
		n_requests = 0;
		n_queries = 0;
		n_results = 0;
		n_fired = 0;
		for (int p = 0; p < PLAYERS; p++)
			for (int b = 0; b < BUTTONS; b++)
				turbo_rates[p][b] = '0;

		// directed: empty table, saturation, periods, unused codes, clears
		queue_cmd(FUNC_QUERY, 1'b0, 4'd0, 6'd0, 64'd0);
		queue_cmd(FUNC_READ, 1'b0, 4'd0, 6'd0, 64'd0);
		queue_cmd(FUNC_ARM, 1'b0, 4'd0, 6'd1, 64'd0);
		queue_cmd(FUNC_ARM, 1'b0, 4'd15, 6'd63, 64'd0);
		queue_cmd(FUNC_ARM, 1'b0, 4'd1, 6'd60, 64'd0);
		queue_cmd(FUNC_ARM, 1'b0, 4'd2, 6'd7, 64'd0);
		queue_cmd(FUNC_ARM, 1'b0, 4'd3, 6'd59, 64'd0);
		queue_cmd(FUNC_READ, 1'b0, 4'd15, 6'd0, 64'd0);
		queue_cmd(FUNC_READ, 1'b0, 4'd2, 6'd0, 64'd0);
		queue_cmd(FUNC_QUERY, 1'b0, 4'd0, 6'd0, 64'd0);
		queue_cmd(FUNC_QUERY, 1'b0, 4'd0, 6'd0, '1);
		queue_cmd(FUNC_QUERY, 1'b0, 4'd0, 6'd0, 64'd8);
		queue_cmd(FUNC_QUERY, 1'b1, 4'd0, 6'd0, 64'd0);
		queue_cmd(FUNC_ARM, 1'b1, 4'd7, 6'd31, 64'd0);
		queue_cmd(FUNC_QUERY, 1'b1, 4'd0, 6'd0, 64'd1);
		queue_cmd(FUNC_UNUSED_FIRST, 1'b0, 4'd5, 6'd12, 64'd60);
		queue_cmd(FUNC_UNUSED_LAST, 1'b1, '1, '1, '1);
		queue_cmd(FUNC_ARM, 1'b0, 4'd1, 6'd0, 64'd0);
		queue_cmd(FUNC_READ, 1'b0, 4'd1, 6'd0, 64'd0);
		queue_cmd(FUNC_CLR_PLAYER, 1'b0, 4'd0, 6'd0, 64'd0);
		queue_cmd(FUNC_QUERY, 1'b0, 4'd0, 6'd0, 64'd120);
		queue_cmd(FUNC_READ, 1'b1, 4'd7, 6'd0, 64'd0);
		queue_cmd(FUNC_CLR_ALL, 1'b1, 4'd0, 6'd0, 64'd0);
		queue_cmd(FUNC_READ, 1'b1, 4'd7, 6'd0, 64'd0);

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// idling phases: none, sender idle, receiver stalling, both
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
				1: begin src_idle_pct = 76; sink_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  sink_stall_pct = 76; end
				default: begin src_idle_pct = 10; sink_stall_pct = 10; end
			endcase
			for (int i = 0; i < N_RANDOM; i++)
				cmd_backlog = {cmd_backlog, random_cmd()};
			while (cmd_backlog.size() != 0 || req_ch.valid || turbo_expected.size() != 0)
				@(posedge clk);
		end

		repeat (DRAIN_WAIT) @(posedge clk);
		$display("covered %0d requests over four idling phases, %0d of them frame queries",
			n_requests, n_queries);
		$display("%0d responses checked, %0d with buttons pressed", n_results, n_fired);
		if (err_count == 0 && turbo_expected.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/afbo_pkg.sv
rtl/afbo_if.sv
rtl/afbo_mod.sv
rtl/afbo_table.sv
rtl/autofire_button_overlay.sv
test/tb_autofire_button_overlay.sv
